// ===== src/mhs_pkg.sv =====
`default_nettype none
package mhs_pkg;
	localparam int COORD_BITS_DEF = 12;
	localparam int ANGLE_FRAC_DEF = 8;
	localparam int RANGE_FRAC_DEF = 4;
	localparam int CORDIC_STEPS = 20;
	localparam int CORDIC_FRAC = 20;
	localparam int PRE_SHIFT = 16;
	localparam int CW = 56;

	localparam logic [1:0] MODE_FRONT = 2'd0;
	localparam logic [1:0] MODE_REAR = 2'd1;
	localparam logic [1:0] MODE_USER = 2'd2;
	localparam logic [1:0] MODE_STATION = 2'd3;

	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_LEFT = 2'd1;
	localparam logic [1:0] CMD_RIGHT = 2'd2;
	localparam logic [1:0] CMD_FWD = 2'd3;

	localparam logic [1:0] REG_TURN_RATE = 2'd0;
	localparam logic [1:0] REG_DRIVE_SPEED = 2'd1;
	localparam logic [1:0] REG_ANGLE_DB = 2'd2;
	localparam logic [1:0] REG_DIST_DB = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [11:0] corner0_x;
		logic [11:0] corner0_y;
		logic [11:0] corner1_x;
		logic [11:0] corner1_y;
		logic [11:0] corner2_x;
		logic [11:0] corner2_y;
		logic [11:0] corner3_x;
		logic [11:0] corner3_y;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] heading_error;
		logic [16:0] station_range;
		logic turn_right;
		logic geometry_updated;
		logic [1:0] command;
		logic [20:0] duration;
	} out_beat_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CENTRE, ST_PROD, ST_CORDIC, ST_ANGLE, ST_CMD, ST_DIV, ST_DUR, ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
	} unit_ctl_t;

	function automatic logic [CW-1:0] atan_entry(input logic [4:0] i);
		case (i)
			5'd0: atan_entry = CW'(47185920);
			5'd1: atan_entry = CW'(27855475);
			5'd2: atan_entry = CW'(14718068);
			5'd3: atan_entry = CW'(7471121);
			5'd4: atan_entry = CW'(3750058);
			5'd5: atan_entry = CW'(1876857);
			5'd6: atan_entry = CW'(938658);
			5'd7: atan_entry = CW'(469357);
			5'd8: atan_entry = CW'(234682);
			5'd9: atan_entry = CW'(117342);
			5'd10: atan_entry = CW'(58671);
			5'd11: atan_entry = CW'(29335);
			5'd12: atan_entry = CW'(14668);
			5'd13: atan_entry = CW'(7334);
			5'd14: atan_entry = CW'(3667);
			5'd15: atan_entry = CW'(1833);
			5'd16: atan_entry = CW'(917);
			5'd17: atan_entry = CW'(458);
			5'd18: atan_entry = CW'(229);
			5'd19: atan_entry = CW'(115);
			default: atan_entry = '0;
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== src/mhs_cordic.sv =====
`default_nettype none
// Vectoring CORDIC, one micro-rotation per cycle, arithmetic shifts give floor division.
module mhs_cordic (
	input wire logic clk,
	input wire logic arst_n,
	input wire mhs_pkg::unit_ctl_t ctl,
	input wire logic signed [mhs_pkg::CW-1:0] x_init,
	input wire logic signed [mhs_pkg::CW-1:0] y_init,
	input wire logic signed [mhs_pkg::CW-1:0] z_init,
	output logic done,
	output logic signed [mhs_pkg::CW-1:0] z_out
);
	import mhs_pkg::*;
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic [4:0] i_q;
	logic run_q;
	logic signed [CW-1:0] xs, ys, tab;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign tab = $signed(atan_entry(i_q));
	assign z_out = z_q;
	assign done = run_q && (i_q == 5'(CORDIC_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			i_q <= '0;
		end else if (ctl.start) begin
			run_q <= 1'b1;
			i_q <= '0;
		end else if (run_q) begin
			if (done) run_q <= 1'b0;
			else i_q <= i_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= x_init;
			y_q <= y_init;
			z_q <= z_init;
		end else if (run_q) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - tab;
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/mhs_sqrt.sv =====
`default_nettype none
// Bit-pair restoring square root, one result bit per cycle.
module mhs_sqrt #(
	parameter int NW = 48
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire mhs_pkg::unit_ctl_t ctl,
	input wire logic [NW-1:0] radicand,
	output logic done,
	output logic [NW/2-1:0] root
);
	import mhs_pkg::*;
	localparam int RW = NW / 2;
	localparam int CB = $clog2(RW + 1);
	logic [NW-1:0] n_q;
	logic [RW+1:0] rem_q;
	logic [RW-1:0] r_q;
	logic [CB-1:0] k_q;
	logic run_q;
	logic [RW+1:0] trial, cand;

	assign cand = {rem_q[RW-1:0], n_q[NW-1 -: 2]};
	assign trial = cand - {r_q, 2'b01};
	assign root = r_q;
	assign done = run_q && (k_q == CB'(RW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			k_q <= '0;
		end else if (ctl.start) begin
			run_q <= 1'b1;
			k_q <= '0;
		end else if (run_q) begin
			if (done) run_q <= 1'b0;
			else k_q <= k_q + CB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			n_q <= radicand;
			rem_q <= '0;
			r_q <= '0;
		end else if (run_q) begin
			n_q <= n_q << 2;
			if (!trial[RW+1]) begin
				rem_q <= trial;
				r_q <= {r_q[RW-2:0], 1'b1};
			end else begin
				rem_q <= cand;
				r_q <= {r_q[RW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/mhs_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module mhs_div #(
	parameter int NW = 32,
	parameter int DW = 20
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire mhs_pkg::unit_ctl_t ctl,
	input wire logic [NW-1:0] numer,
	input wire logic [DW-1:0] denom,
	output logic done,
	output logic [NW-1:0] quot
);
	import mhs_pkg::*;
	localparam int CB = $clog2(NW + 1);
	logic [NW-1:0] q_q;
	logic [DW:0] rem_q;
	logic [DW-1:0] d_q;
	logic [CB-1:0] k_q;
	logic run_q;
	logic [DW:0] sh, diff;

	assign sh = {rem_q[DW-1:0], q_q[NW-1]};
	assign diff = sh - {1'b0, d_q};
	assign quot = q_q;
	assign done = run_q && (k_q == CB'(NW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			k_q <= '0;
		end else if (ctl.start) begin
			run_q <= 1'b1;
			k_q <= '0;
		end else if (run_q) begin
			if (done) run_q <= 1'b0;
			else k_q <= k_q + CB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			q_q <= numer;
			rem_q <= '0;
			d_q <= denom;
		end else if (run_q) begin
			if (!diff[DW]) begin
				rem_q <= diff;
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/marker_heading_steering_top.sv =====
`default_nettype none
// Marker heading steering.
// Input channel (in_valid/in_ready, in_data) takes one marker report per beat: a
// mode and four corners. Front, rear and station marker centres are stored; the
// robot heading and the goal are then compared, and one result beat leaves on
// the output channel (out_valid/out_ready, out_data) for every input beat.
// The result carries the held angle (Q8.8 degrees), range (Q13.4 pixels), turn
// side, an update flag and a turn, forward or no-op command with a duration.
// The steps from the accept edge to out_valid, when the geometry is recomputed and a
// command is issued: centre, products, CORDIC with the 18 square-root steps
// alongside, angle, command, divider, quotient. With no geometry update the
// CORDIC and angle steps are skipped; with no command the divider and quotient
// steps are skipped. in_ready returns only after the result beat is taken, so
// the block takes no new item while the previous one is in flight.
// A result waits in the output register while out_ready is low; the next item
// is taken once it has left. Reset clears the stored marker positions, the held
// values and restores the register defaults; no clearing pass is needed.
// Registers on the APB port: turn_rate 0x0, drive_speed 0x4, angle_deadband 0x8,
// distance_deadband 0xC. Write them only while the block is idle.
module marker_heading_steering_top #(
	parameter int ANGLE_FRAC_BITS = mhs_pkg::ANGLE_FRAC_DEF,
	parameter int RANGE_FRAC_BITS = mhs_pkg::RANGE_FRAC_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire mhs_pkg::in_beat_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output mhs_pkg::out_beat_t out_data,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import mhs_pkg::*;
	localparam int CB = COORD_BITS_DEF;
	localparam int DV = CB + 2;              // signed vector component
	localparam int PW = 2 * DV + 2;          // dot / cross width
	localparam int SQW = 2 * (CB + 1 + RANGE_FRAC_BITS) + 2;
	localparam int SQRW = SQW / 2;
	localparam int NUMW = 32;
	localparam int DENW = 8 + 12;
	localparam int ASH = CORDIC_FRAC - ANGLE_FRAC_BITS;

	state_t state_q, state_d;

	logic [7:0] turn_rate_q, drive_speed_q, angle_db_q;
	logic [12:0] dist_db_q;
	logic [1:0] reg_idx;
	logic wr_en;

	logic [CB-1:0] front_x_q, front_y_q, rear_x_q, rear_y_q, goal_x_q, goal_y_q;
	logic [15:0] held_angle_q;
	logic [16:0] held_range_q;
	logic held_side_q;
	logic upd_q;
	in_beat_t in_q;
	out_beat_t out_q;

	logic signed [PW-1:0] dot_q, crs_q;
	logic [SQW-1:0] sq_q;
	logic [1:0] cmd_q;
	logic sqrt_done_q, cordic_done_q;

	// Register file
	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_rate_q <= 8'd10;
			drive_speed_q <= 8'd52;
			angle_db_q <= 8'd5;
			dist_db_q <= 13'd10;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_TURN_RATE: turn_rate_q <= pwdata[7:0];
				REG_DRIVE_SPEED: drive_speed_q <= pwdata[7:0];
				REG_ANGLE_DB: angle_db_q <= pwdata[7:0];
				REG_DIST_DB: dist_db_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TURN_RATE: prdata = {24'd0, turn_rate_q};
			REG_DRIVE_SPEED: prdata = {24'd0, drive_speed_q};
			REG_ANGLE_DB: prdata = {24'd0, angle_db_q};
			REG_DIST_DB: prdata = {19'd0, dist_db_q};
			default: prdata = '0;
		endcase
	end

	// Marker centre
	logic [CB+1:0] sum_x, sum_y;
	logic [CB-1:0] mx, my;
	assign sum_x = (CB+2)'(in_q.corner0_x[CB-1:0]) + (CB+2)'(in_q.corner1_x[CB-1:0])
		+ (CB+2)'(in_q.corner2_x[CB-1:0]) + (CB+2)'(in_q.corner3_x[CB-1:0]);
	assign sum_y = (CB+2)'(in_q.corner0_y[CB-1:0]) + (CB+2)'(in_q.corner1_y[CB-1:0])
		+ (CB+2)'(in_q.corner2_y[CB-1:0]) + (CB+2)'(in_q.corner3_y[CB-1:0]);
	assign mx = sum_x[CB+1:2];
	assign my = sum_y[CB+1:2];

	// Vectors from the stored positions
	logic [CB:0] csx, csy;
	logic [CB-1:0] rx, ry;
	logic signed [DV-1:0] ax_c, ay_c, bx_c, by_c;
	assign csx = (CB+1)'(front_x_q) + (CB+1)'(rear_x_q);
	assign csy = (CB+1)'(front_y_q) + (CB+1)'(rear_y_q);
	assign rx = csx[CB:1];
	assign ry = csy[CB:1];
	assign ax_c = $signed(DV'(front_x_q)) - $signed(DV'(rx));
	assign ay_c = $signed(DV'(front_y_q)) - $signed(DV'(ry));
	assign bx_c = $signed(DV'(goal_x_q)) - $signed(DV'(rx));
	assign by_c = $signed(DV'(goal_y_q)) - $signed(DV'(ry));

	// Judged in ST_PROD, when the positions already hold this item's marker.
	logic valid_geo;
	assign valid_geo = (ax_c != '0 || ay_c != '0) && (bx_c != '0 || by_c != '0);

	// CORDIC start vector
	logic [PW-1:0] abs_c, neg_d;
	logic signed [CW-1:0] cx0, cy0, cz0;
	assign abs_c = crs_q[PW-1] ? PW'(-crs_q) : PW'(crs_q);
	assign neg_d = PW'(-dot_q);
	always_comb begin
		if (!dot_q[PW-1]) begin
			cx0 = $signed(CW'(dot_q) << PRE_SHIFT);
			cy0 = $signed(CW'(abs_c) << PRE_SHIFT);
			cz0 = '0;
		end else begin
			cx0 = $signed(CW'(abs_c) << PRE_SHIFT);
			cy0 = $signed(CW'(neg_d) << PRE_SHIFT);
			cz0 = $signed(CW'(90) << CORDIC_FRAC);
		end
	end

	unit_ctl_t div_ctl;
	logic cordic_done, sqrt_done, div_done;
	logic signed [CW-1:0] z_res;
	logic [SQRW-1:0] root;
	logic [NUMW-1:0] quot;

	// Both units start together on the cycle after the products are registered.
	logic start_q;
	unit_ctl_t go_ctl;
	assign go_ctl = '{start: start_q};

	mhs_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .ctl(go_ctl),
		.x_init(cx0), .y_init(cy0), .z_init(cz0),
		.done(cordic_done), .z_out(z_res)
	);

	mhs_sqrt #(.NW(SQW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .ctl(go_ctl),
		.radicand(sq_q), .done(sqrt_done), .root(root)
	);

	// Angle rounding and range saturation
	logic signed [CW-1:0] z_cl;
	logic [CW-1:0] z_rnd;
	logic [15:0] ang_v;
	logic [16:0] rng_v;
	always_comb begin
		if (z_res[CW-1]) z_cl = '0;
		else if (z_res > $signed(CW'(180) << CORDIC_FRAC)) z_cl = $signed(CW'(180) << CORDIC_FRAC);
		else z_cl = z_res;
		z_rnd = (CW'(z_cl) + (CW'(1) << (ASH - 1))) >> ASH;
		ang_v = (z_rnd > CW'(16'hFFFF)) ? 16'hFFFF : z_rnd[15:0];
		rng_v = (SQRW'(root) > SQRW'(17'h1FFFF)) ? 17'h1FFFF : root[16:0];
	end

	// Command decision and divider operands
	logic turn_sel, fwd_sel;
	logic [NUMW-1:0] numer;
	logic [DENW-1:0] denom;
	assign turn_sel = 24'(held_angle_q) > (24'(angle_db_q) << ANGLE_FRAC_BITS);
	assign fwd_sel = 32'(held_range_q) > (32'(dist_db_q) << RANGE_FRAC_BITS);
	always_comb begin
		if (cmd_q != CMD_FWD) begin
			numer = NUMW'(held_angle_q) * NUMW'(200);
			denom = DENW'(turn_rate_q) << ANGLE_FRAC_BITS;
		end else begin
			numer = NUMW'(held_range_q) * NUMW'(200);
			denom = DENW'(drive_speed_q) << RANGE_FRAC_BITS;
		end
	end

	logic div_start_q;
	assign div_ctl = '{start: div_start_q};

	mhs_div #(.NW(NUMW), .DW(DENW)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl),
		.numer(numer), .denom(denom), .done(div_done), .quot(quot)
	);

	logic [20:0] dur_v;
	assign dur_v = (quot > NUMW'(21'h1FFFFF)) ? 21'h1FFFFF : quot[20:0];

	// Sequencer. The last quotient bit lands at the edge that leaves ST_DIV, so
	// the quotient is captured in ST_DUR, after it is complete.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_CENTRE;
			ST_CENTRE: state_d = ST_PROD;
			ST_PROD: state_d = valid_geo ? ST_CORDIC : ST_CMD;
			ST_CORDIC: if ((cordic_done || cordic_done_q) && (sqrt_done || sqrt_done_q)
				&& !start_q) state_d = ST_ANGLE;
			ST_ANGLE: state_d = ST_CMD;
			ST_CMD: state_d = (turn_sel || fwd_sel) ? ST_DIV : ST_OUT;
			ST_DIV: if (div_done) state_d = ST_DUR;
			ST_DUR: state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_x_q <= '0; front_y_q <= '0;
			rear_x_q <= '0; rear_y_q <= '0;
			goal_x_q <= '0; goal_y_q <= '0;
			held_angle_q <= '0; held_range_q <= '0; held_side_q <= 1'b0;
			start_q <= 1'b0; div_start_q <= 1'b0;
			cordic_done_q <= 1'b0; sqrt_done_q <= 1'b0;
		end else begin
			start_q <= (state_q == ST_PROD) && valid_geo;
			div_start_q <= (state_q == ST_CMD) && (turn_sel || fwd_sel);
			if (start_q) begin
				cordic_done_q <= 1'b0;
				sqrt_done_q <= 1'b0;
			end else begin
				if (cordic_done) cordic_done_q <= 1'b1;
				if (sqrt_done) sqrt_done_q <= 1'b1;
			end
			if (state_q == ST_CENTRE) begin
				unique case (in_q.mode)
					MODE_FRONT: begin front_x_q <= mx; front_y_q <= my; end
					MODE_REAR: begin rear_x_q <= mx; rear_y_q <= my; end
					MODE_STATION: begin goal_x_q <= mx; goal_y_q <= my; end
					MODE_USER: ;
					default: ;
				endcase
			end
			if (state_q == ST_ANGLE) begin
				held_angle_q <= ang_v;
				held_range_q <= rng_v;
				held_side_q <= !crs_q[PW-1] && (crs_q != '0);
			end
		end
	end

	// Operand registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_q <= in_data;
			upd_q <= 1'b0;
		end
		if (state_q == ST_CENTRE) begin
			upd_q <= 1'b0;
		end
		if (state_q == ST_ANGLE) upd_q <= 1'b1;
		if (state_q == ST_CMD) begin
			if (turn_sel) cmd_q <= held_side_q ? CMD_RIGHT : CMD_LEFT;
			else if (fwd_sel) cmd_q <= CMD_FWD;
			else cmd_q <= CMD_NONE;
		end
		if (state_d == ST_OUT && state_q != ST_OUT) begin
			out_q.heading_error <= held_angle_q;
			out_q.station_range <= held_range_q;
			out_q.turn_right <= held_side_q;
			out_q.geometry_updated <= upd_q;
			out_q.command <= (state_q == ST_CMD) ? CMD_NONE : cmd_q;
			out_q.duration <= (state_q == ST_CMD) ? 21'd0 : dur_v;
		end
	end

	// Products of the vectors from the updated positions, registered for the units.
	always_ff @(posedge clk) begin
		if (state_q == ST_PROD) begin
			dot_q <= PW'(ax_c * bx_c) + PW'(ay_c * by_c);
			crs_q <= PW'(ax_c * by_c) - PW'(ay_c * bx_c);
			sq_q <= (SQW'(PW'(bx_c * bx_c)) + SQW'(PW'(by_c * by_c))) << (2 * RANGE_FRAC_BITS);
		end
	end
endmodule
`default_nettype wire

// ===== tb/tb_marker_heading_steering_top.sv =====
`default_nettype none
module tb_marker_heading_steering_top;
	import mhs_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_beat_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	marker_heading_steering_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	in_beat_t marker_q[$];
	out_beat_t steer_q[$];
	int unsigned sender_idle = 0;
	int unsigned receiver_stall = 0;
	int errors = 0;

	// Shadow of the configuration and of the stored geometry.
	logic [7:0] rate_turn = 8'd10;
	logic [7:0] rate_drive = 8'd52;
	logic [7:0] db_angle = 8'd5;
	logic [12:0] db_dist = 13'd10;
	logic [11:0] fx = '0, fy = '0, rx = '0, ry = '0, gx = '0, gy = '0;
	logic [15:0] keep_angle = '0;
	logic [16:0] keep_range = '0;
	logic keep_side = 1'b0;

	function automatic longint atan_step(int i);
		longint tab[20] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
			938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
			917, 458, 229, 115};
		return tab[i];
	endfunction

	function automatic logic [15:0] cordic_angle(longint d, longint c);
		longint ac, x, y, z, nx;
		longint unsigned r;
		ac = (c < 0) ? -c : c;
		if (d >= 0) begin
			x = d <<< 16; y = ac <<< 16; z = 0;
		end else begin
			x = ac <<< 16; y = (-d) <<< 16; z = longint'(90) <<< 20;
		end
		for (int i = 0; i < 20; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i); y = y - (x >>> i); z += atan_step(i);
			end else begin
				nx = x - (y >>> i); y = y + (x >>> i); z -= atan_step(i);
			end
			x = nx;
		end
		if (z < 0) z = 0;
		if (z > (longint'(180) <<< 20)) z = longint'(180) <<< 20;
		r = (longint'(z) + (longint'(1) <<< 11)) >> 12;
		return (r > 64'hFFFF) ? 16'hFFFF : r[15:0];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b; r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [20:0] travel_time(longint unsigned value,
			longint unsigned divisor, int frac);
		longint unsigned den, q;
		den = divisor << frac;
		if (den == 0) return 21'h1FFFFF;
		q = (value * 200) / den;
		return (q > 64'h1FFFFF) ? 21'h1FFFFF : q[20:0];
	endfunction

	function automatic out_beat_t predict_steer(in_beat_t m);
		out_beat_t o;
		logic [11:0] mx, my;
		longint cx, cy, ax, ay, bx, by, d, c;
		longint unsigned rg;
		o = '0;
		mx = 12'((14'(m.corner0_x) + m.corner1_x + m.corner2_x + m.corner3_x) >> 2);
		my = 12'((14'(m.corner0_y) + m.corner1_y + m.corner2_y + m.corner3_y) >> 2);
		case (m.mode)
			MODE_FRONT: begin fx = mx; fy = my; end
			MODE_REAR: begin rx = mx; ry = my; end
			MODE_STATION: begin gx = mx; gy = my; end
			default: ;
		endcase
		cx = (longint'(fx) + rx) >> 1;
		cy = (longint'(fy) + ry) >> 1;
		ax = longint'(fx) - cx; ay = longint'(fy) - cy;
		bx = longint'(gx) - cx; by = longint'(gy) - cy;
		if ((ax != 0 || ay != 0) && (bx != 0 || by != 0)) begin
			d = ax * bx + ay * by;
			c = ax * by - ay * bx;
			rg = int_sqrt(longint'(bx * bx + by * by) << 8);
			keep_angle = cordic_angle(d, c);
			keep_range = (rg > 64'h1FFFF) ? 17'h1FFFF : rg[16:0];
			keep_side = (c > 0);
			o.geometry_updated = 1'b1;
		end
		if (keep_angle > (16'(db_angle) << 8)) begin
			o.command = keep_side ? CMD_RIGHT : CMD_LEFT;
			o.duration = travel_time(keep_angle, rate_turn, 8);
		end else if (keep_range > (17'(db_dist) << 4)) begin
			o.command = CMD_FWD;
			o.duration = travel_time(keep_range, rate_drive, 4);
		end else begin
			o.command = CMD_NONE;
			o.duration = '0;
		end
		o.heading_error = keep_angle;
		o.station_range = keep_range;
		o.turn_right = keep_side;
		return o;
	endfunction

	// Driver: the next beat is presented only once the current one is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) steer_q = {steer_q, predict_steer(in_data)};
			if (!in_valid || in_ready) begin
				if (marker_q.size() > 0 && $urandom_range(99) >= sender_idle) begin
					in_valid <= 1'b1;
					in_data <= marker_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (steer_q.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					out_beat_t e;
					e = steer_q.pop_front();
					if (out_data.heading_error !== e.heading_error) begin
						$error("heading_error exp %0d got %0d", e.heading_error,
							out_data.heading_error);
						errors++;
					end
					if (out_data.station_range !== e.station_range) begin
						$error("station_range exp %0d got %0d", e.station_range,
							out_data.station_range);
						errors++;
					end
					if (out_data.turn_right !== e.turn_right) begin
						$error("turn_right exp %0d got %0d", e.turn_right, out_data.turn_right);
						errors++;
					end
					if (out_data.geometry_updated !== e.geometry_updated) begin
						$error("geometry_updated exp %0d got %0d", e.geometry_updated,
							out_data.geometry_updated);
						errors++;
					end
					if (out_data.command !== e.command) begin
						$error("command exp %0d got %0d", e.command, out_data.command);
						errors++;
					end
					if (out_data.duration !== e.duration) begin
						$error("duration exp %0d got %0d", e.duration, out_data.duration);
						errors++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= receiver_stall);
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_TURN_RATE: rate_turn = value[7:0];
			REG_DRIVE_SPEED: rate_drive = value[7:0];
			REG_ANGLE_DB: db_angle = value[7:0];
			default: db_dist = value[12:0];
		endcase
	endtask

	task automatic set_regs(int tr, int ds, int adb, int ddb);
		reg_write(REG_TURN_RATE, tr);
		reg_write(REG_DRIVE_SPEED, ds);
		reg_write(REG_ANGLE_DB, adb);
		reg_write(REG_DIST_DB, ddb);
	endtask

	task automatic drain();
		while (marker_q.size() > 0 || in_valid || steer_q.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [11:0] clip(int v);
		return (v < 0) ? 12'd0 : (v > 4095) ? 12'd4095 : 12'(v);
	endfunction

	// Four corners around a centre; jitter keeps the floor average near it.
	task automatic add_marker(logic [1:0] mode, int x, int y, int jit);
		in_beat_t m;
		m.mode = mode;
		m.corner0_x = clip(x - $urandom_range(jit)); m.corner0_y = clip(y - $urandom_range(jit));
		m.corner1_x = clip(x + $urandom_range(jit)); m.corner1_y = clip(y - $urandom_range(jit));
		m.corner2_x = clip(x + $urandom_range(jit)); m.corner2_y = clip(y + $urandom_range(jit));
		m.corner3_x = clip(x - $urandom_range(jit)); m.corner3_y = clip(y + $urandom_range(jit));
		marker_q = {marker_q, m};
	endtask

	task automatic add_random_scene(int count);
		int cx, cy, hx, hy, sx, sy;
		in_beat_t m;
		for (int n = 0; n < count; n++) begin
			if (n % 30 == 0) begin
				cx = $urandom_range(3900, 200); cy = $urandom_range(3900, 200);
				hx = int'($urandom_range(300)) - 150; hy = int'($urandom_range(300)) - 150;
				sx = $urandom_range(4095); sy = $urandom_range(4095);
			end
			if ($urandom_range(9) == 0) begin
				// Nudge the goal close to the robot for small ranges and deadband edges.
				sx = cx + int'($urandom_range(40)) - 20; sy = cy + int'($urandom_range(40)) - 20;
			end
			if ($urandom_range(99) < 15) begin
				m = in_beat_t'({$urandom, $urandom, $urandom});
				marker_q = {marker_q, m};
			end else begin
				case ($urandom_range(3))
					0: add_marker(MODE_FRONT, cx + hx, cy + hy, $urandom_range(3));
					1: add_marker(MODE_REAR, cx - hx, cy - hy, $urandom_range(3));
					2: add_marker(MODE_USER, $urandom_range(4095), $urandom_range(4095), 3);
					default: add_marker(MODE_STATION, sx, sy, $urandom_range(3));
				endcase
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero vectors from reset, field extremes, aligned, opposite, behind.
		add_marker(MODE_USER, 0, 0, 0);
		add_marker(MODE_FRONT, 4095, 4095, 0);
		add_marker(MODE_STATION, 4095, 4095, 0);
		add_marker(MODE_REAR, 0, 0, 0);
		add_marker(MODE_STATION, 0, 0, 0);
		add_marker(MODE_STATION, 2047, 2047, 0);
		add_marker(MODE_STATION, 4095, 0, 0);
		add_marker(MODE_STATION, 0, 4095, 0);
		add_marker(MODE_FRONT, 2000, 1000, 0);
		add_marker(MODE_REAR, 2000, 1000, 0);
		add_marker(MODE_FRONT, 2100, 1000, 0);
		add_marker(MODE_STATION, 2050, 1000, 0);
		add_marker(MODE_STATION, 2050, 1200, 0);
		add_marker(MODE_STATION, 2050, 800, 0);
		add_marker(MODE_STATION, 2052, 1000, 0);
		add_marker(MODE_STATION, 2064, 1001, 0);
		add_marker(MODE_STATION, 2070, 1000, 0);
		add_marker(MODE_USER, 4095, 4095, 0);
		marker_q = {marker_q, in_beat_t'{MODE_STATION, 12'hFFF, 12'h0, 12'h0, 12'hFFF,
			12'hFFF, 12'h0, 12'h0, 12'hFFF}};
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: ;
				1: set_regs(1, 1, 0, 0);
				2: set_regs(255, 255, 180, 8191);
				3: set_regs($urandom_range(255, 1), $urandom_range(255, 1),
					$urandom_range(30), $urandom_range(300));
				4: set_regs(0, 0, 0, 0);
				default: set_regs($urandom_range(255, 1), $urandom_range(255, 1),
					$urandom_range(180), $urandom_range(8191));
			endcase
			case (ph % 4)
				0: begin sender_idle = 0; receiver_stall = 0; end
				1: begin sender_idle = 53; receiver_stall = 0; end
				2: begin sender_idle = 0; receiver_stall = 53; end
				default: begin sender_idle = 14; receiver_stall = 14; end
			endcase
			add_random_scene(120);
			// Let the pipeline empty completely before the second half.
			while (marker_q.size() > 0 || in_valid || steer_q.size() > 0) @(posedge clk);
			add_random_scene(120);
			drain();
		end

		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#60000000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
src/mhs_pkg.sv
src/mhs_cordic.sv
src/mhs_sqrt.sv
src/mhs_div.sv
src/marker_heading_steering_top.sv
tb/tb_marker_heading_steering_top.sv
